>>> hdl/assert_macros.svh
// Assertion helpers shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define C2U_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c2u check failed");

// Next-cycle implication, disabled in reset.
`define C2U_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c2u check failed");

`endif

>>> hdl/c2u_pkg.sv
`timescale 1ns / 1ps
package c2u_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] MODE_UTF8   = 2'd0;
  localparam logic [1:0] MODE_ASCII  = 2'd1;
  localparam logic [1:0] MODE_LATIN1 = 2'd2;
  localparam logic [1:0] MODE_CP1252 = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CHARSET = 2'd1;
  localparam logic [1:0] ERR_UTF8    = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        run_last;
    logic        text_done;
    logic [1:0]  error_code;
    logic [31:0] total_length;
  } out_item_t;

  // One classified source byte, waiting to be serialized.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            last;
    logic            err;
    logic [1:0]      err_code;
    logic [31:0]     base_len;
  } q_item_t;

  // Windows-1252 upper control range; zero marks an undefined byte.
  function automatic logic [15:0] cp1252_high(input logic [4:0] idx);
    logic [15:0] cp;
    case (idx)
      5'd0:    cp = 16'h20AC;
      5'd2:    cp = 16'h201A;
      5'd3:    cp = 16'h0192;
      5'd4:    cp = 16'h201E;
      5'd5:    cp = 16'h2026;
      5'd6:    cp = 16'h2020;
      5'd7:    cp = 16'h2021;
      5'd8:    cp = 16'h02C6;
      5'd9:    cp = 16'h2030;
      5'd10:   cp = 16'h0160;
      5'd11:   cp = 16'h2039;
      5'd12:   cp = 16'h0152;
      5'd14:   cp = 16'h017D;
      5'd17:   cp = 16'h2018;
      5'd18:   cp = 16'h2019;
      5'd19:   cp = 16'h201C;
      5'd20:   cp = 16'h201D;
      5'd21:   cp = 16'h2022;
      5'd22:   cp = 16'h2013;
      5'd23:   cp = 16'h2014;
      5'd24:   cp = 16'h02DC;
      5'd25:   cp = 16'h2122;
      5'd26:   cp = 16'h0161;
      5'd27:   cp = 16'h203A;
      5'd28:   cp = 16'h0153;
      5'd30:   cp = 16'h017E;
      5'd31:   cp = 16'h0178;
      default: cp = 16'h0000;
    endcase
    return cp;
  endfunction

endpackage

>>> hdl/c2u_front.sv
`timescale 1ns / 1ps
module c2u_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        mode,
  input  logic              accept,
  input  c2u_pkg::in_item_t in_item,
  output c2u_pkg::q_item_t  q_item
);

  localparam logic [2:0] LC_ANY  = 3'd0;
  localparam logic [2:0] LC_E0   = 3'd1;
  localparam logic [2:0] LC_ED   = 3'd2;
  localparam logic [2:0] LC_F0   = 3'd3;
  localparam logic [2:0] LC_F4   = 3'd4;

  logic        err_r, err_nxt;
  logic [1:0]  cn_r, cn_nxt;
  logic [2:0]  lc_r, lc_nxt;
  logic [31:0] cnt_r, cnt_nxt;

  logic [7:0]  b;
  logic        ok;
  logic        fail;
  logic [1:0]  cn_v;
  logic [2:0]  lc_v;
  logic [7:0]  lo, hi;
  logic [15:0] cp;
  logic [2:0][7:0] bytes;
  logic [1:0]  nb;
  logic [32:0] sum;

  assign b = in_item.in_byte;

  always_comb begin
    err_nxt = err_r;
    cn_nxt  = cn_r;
    lc_nxt  = lc_r;
    cnt_nxt = cnt_r;
    ok      = 1'b0;
    fail    = 1'b0;
    cn_v    = cn_r;
    lc_v    = lc_r;
    lo      = 8'h80;
    hi      = 8'hBF;
    cp      = {8'h00, b};
    bytes   = '0;
    nb      = 2'd1;
    sum     = '0;
    if (!err_r) begin
      if (mode == c2u_pkg::MODE_UTF8) begin
        if (cn_r == 2'd0) begin
          ok = 1'b1;
          if (b inside {[8'h00:8'h7F]}) begin
            cn_v = 2'd0;
          end else if (b inside {[8'hC2:8'hDF]}) begin
            cn_v = 2'd1; lc_v = LC_ANY;
          end else if (b == 8'hE0) begin
            cn_v = 2'd2; lc_v = LC_E0;
          end else if (b == 8'hED) begin
            cn_v = 2'd2; lc_v = LC_ED;
          end else if (b inside {[8'hE1:8'hEF]}) begin
            cn_v = 2'd2; lc_v = LC_ANY;
          end else if (b == 8'hF0) begin
            cn_v = 2'd3; lc_v = LC_F0;
          end else if (b == 8'hF4) begin
            cn_v = 2'd3; lc_v = LC_F4;
          end else if (b inside {[8'hF1:8'hF3]}) begin
            cn_v = 2'd3; lc_v = LC_ANY;
          end else begin
            ok = 1'b0;
          end
        end else begin
          case (lc_r)
            LC_E0:   lo = 8'hA0;
            LC_ED:   hi = 8'h9F;
            LC_F0:   lo = 8'h90;
            LC_F4:   hi = 8'h8F;
            default: ;
          endcase
          ok = (b >= lo) && (b <= hi);
          cn_v = cn_r - 2'd1;
          lc_v = LC_ANY;
        end
        if (ok) begin
          cn_nxt = cn_v;
          lc_nxt = lc_v;
        end
        fail = !ok || (in_item.in_last && cn_v != 2'd0);
        bytes[0] = b;
      end else begin
        if (mode == c2u_pkg::MODE_ASCII && b[7]) begin
          fail = 1'b1;
        end else if (mode == c2u_pkg::MODE_CP1252 && b inside {[8'h80:8'h9F]}) begin
          cp = c2u_pkg::cp1252_high(b[4:0]);
          fail = (cp == 16'h0000);
        end
        if (cp < 16'h0080) begin
          bytes[0] = cp[7:0];
        end else if (cp < 16'h0800) begin
          bytes[0] = {3'b110, cp[10:6]};
          bytes[1] = {2'b10, cp[5:0]};
          nb = 2'd2;
        end else begin
          bytes[0] = {4'b1110, cp[15:12]};
          bytes[1] = {2'b10, cp[11:6]};
          bytes[2] = {2'b10, cp[5:0]};
          nb = 2'd3;
        end
      end
      if (fail) begin
        err_nxt = 1'b1;
      end
    end
    if (!err_nxt) begin
      sum = {1'b0, cnt_r} + {31'd0, nb};
      cnt_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
    q_item.bytes    = bytes;
    q_item.nbytes   = nb;
    q_item.last     = in_item.in_last;
    q_item.err      = err_nxt;
    q_item.err_code = (mode == c2u_pkg::MODE_UTF8) ? c2u_pkg::ERR_UTF8 : c2u_pkg::ERR_CHARSET;
    q_item.base_len = cnt_r;
    if (in_item.in_last) begin
      err_nxt = 1'b0;
      cn_nxt  = 2'd0;
      lc_nxt  = LC_ANY;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= 1'b0;
      cn_r  <= 2'd0;
      lc_r  <= LC_ANY;
      cnt_r <= '0;
    end else if (accept) begin
      err_r <= err_nxt;
      cn_r  <= cn_nxt;
      lc_r  <= lc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hdl/c2u_queue.sv
`timescale 1ns / 1ps
module c2u_queue #(
  parameter int DEPTH = c2u_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  c2u_pkg::q_item_t wr_item,
  output logic             full,
  input  logic             rd,
  output c2u_pkg::q_item_t rd_item,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  c2u_pkg::q_item_t mem [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign rd_item = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) begin
      wp_nxt = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
    end
    if (rd) begin
      rp_nxt = (rp_r == LAST_IDX) ? '0 : rp_r + 1'b1;
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hdl/c2u_back.sv
`timescale 1ns / 1ps
module c2u_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  c2u_pkg::q_item_t   q_item,
  output logic               q_rd,
  output logic               empty,
  input  logic               pop,
  output c2u_pkg::out_item_t out_item
);

  logic               valid_r, valid_nxt;
  c2u_pkg::out_item_t item_r, item_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic               load;
  logic               fin;
  logic [32:0]        sum;

  assign empty    = !valid_r;
  assign out_item = item_r;
  assign load     = !q_empty && (!valid_r || pop);
  assign fin      = q_item.err || (idx_r == q_item.nbytes - 2'd1);
  assign q_rd     = load && fin;

  always_comb begin
    sum       = {1'b0, q_item.base_len} + {31'd0, idx_r} + 33'd1;
    item_nxt  = item_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt          = 1'b1;
      item_nxt.run_last  = fin;
      item_nxt.text_done = fin && q_item.last;
      idx_nxt            = fin ? 2'd0 : idx_r + 2'd1;
      if (q_item.err) begin
        item_nxt.out_byte     = 8'h00;
        item_nxt.error_code   = q_item.err_code;
        item_nxt.total_length = q_item.base_len;
      end else begin
        item_nxt.out_byte     = q_item.bytes[idx_r];
        item_nxt.error_code   = c2u_pkg::ERR_NONE;
        item_nxt.total_length = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

>>> hdl/charset_to_utf8_converter.sv
`timescale 1ns / 1ps
// Source-text to UTF-8 transcoder. Source bytes are pushed one per clock and
// classified at once by the front end (UTF-8 check, ASCII, Latin-1 or
// Windows-1252 mapping), then queued, QDEPTH items deep, for the back end,
// which sends the resulting UTF-8 bytes through an output register at one
// byte per clock while the output is popped. An input byte thus yields one to
// three output bytes: one for ASCII text, errors and UTF-8 pass-through, two
// for Latin-1 above 0x7F, up to three for Windows-1252 punctuation. A pushed
// byte passes through a queue entry and then the output register before it
// is shown. The output byte rate of the back end sets the sustained
// throughput; push stalls only when the queue is full. cfg_charset_mode is
// always ready and must be written while the block is idle.
module charset_to_utf8_converter #(
  parameter int QDEPTH = c2u_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  c2u_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output c2u_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_charset_mode
);

  logic [1:0]       mode_q_r;
  logic             accept;
  c2u_pkg::q_item_t f_item;
  c2u_pkg::q_item_t h_item;
  logic             q_rd;
  logic             q_empty;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_q_r <= c2u_pkg::MODE_UTF8;
    end else if (cfg_valid && cfg_ready) begin
      mode_q_r <= cfg_charset_mode;
    end
  end

  c2u_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (mode_q_r),
    .accept  (accept),
    .in_item (in_item),
    .q_item  (f_item)
  );

  c2u_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (accept),
    .wr_item (f_item),
    .full    (full),
    .rd      (q_rd),
    .rd_item (h_item),
    .empty   (q_empty)
  );

  c2u_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (h_item),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

>>> hdl/c2u_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module c2u_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               empty,
  input logic               pop,
  input c2u_pkg::out_item_t out_item
);

  logic shown;
  logic err_shown;
  logic done_pop;

  assign shown     = !empty;
  assign err_shown = shown && (out_item.error_code != c2u_pkg::ERR_NONE);
  assign done_pop  = shown && pop && out_item.text_done;

  `C2U_ASSERT_NOW(a_err_zero, clk, rst_n, err_shown, out_item.out_byte == 8'h00 && out_item.run_last)
  `C2U_ASSERT_NOW(a_done_last, clk, rst_n, shown && out_item.text_done, out_item.run_last)
  `C2U_ASSERT_NOW(a_code_legal, clk, rst_n, shown, out_item.error_code != 2'd3)
  `C2U_ASSERT_NEXT(a_hold, clk, rst_n, shown && !pop, !empty && $stable(out_item))
  `C2U_ASSERT_NEXT(a_len_restart, clk, rst_n, done_pop, empty || out_item.total_length <= 32'd3)

endmodule

bind charset_to_utf8_converter c2u_checker u_chk (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  typedef enum logic [2:0] {LB_ANY, LB_E0, LB_ED, LB_F0, LB_F4} lead_bound_t;

  typedef struct {
    logic [1:0]         mode;
    logic [7:0]         b;
    logic               l;
    bit                 typed;
    c2u_pkg::out_item_t res;
  } row_t;

  localparam logic [15:0] WIN_HI [32] = '{
    16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
    16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
  };

  localparam c2u_pkg::out_item_t NO_RES = '0;
  localparam int NUM_ROWS = 26;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  c2u_pkg::in_item_t  in_item = '0;
  logic               empty;
  logic               pop = 1'b0;
  c2u_pkg::out_item_t out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_charset_mode = c2u_pkg::MODE_UTF8;

  logic [1:0]  cur_mode = c2u_pkg::MODE_UTF8;
  bit          err_flag = 1'b0;
  logic [1:0]  cont_left = '0;
  lead_bound_t lead_bound = LB_ANY;
  logic [31:0] len_count = '0;

  c2u_pkg::out_item_t utf8_due[$];
  logic [7:0]  text_bytes[$];
  int          errs = 0;
  int          pops_seen = 0;
  int          bytes_sent = 0;
  bit          tx_calm = 1'b0;
  row_t        rows [NUM_ROWS];

  charset_to_utf8_converter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_item          (in_item),
    .empty            (empty),
    .pop              (pop),
    .out_item         (out_item),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_charset_mode (cfg_charset_mode)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic bit utf8_step(input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (cont_left == 0) begin
      if (b < 8'h80) return 1'b1;
      if (b >= 8'hC2 && b <= 8'hDF) begin
        cont_left = 2'd1;
        lead_bound = LB_ANY;
        return 1'b1;
      end
      if (b == 8'hE0) begin
        cont_left = 2'd2;
        lead_bound = LB_E0;
        return 1'b1;
      end
      if (b == 8'hED) begin
        cont_left = 2'd2;
        lead_bound = LB_ED;
        return 1'b1;
      end
      if (b >= 8'hE1 && b <= 8'hEF) begin
        cont_left = 2'd2;
        lead_bound = LB_ANY;
        return 1'b1;
      end
      if (b == 8'hF0) begin
        cont_left = 2'd3;
        lead_bound = LB_F0;
        return 1'b1;
      end
      if (b == 8'hF4) begin
        cont_left = 2'd3;
        lead_bound = LB_F4;
        return 1'b1;
      end
      if (b >= 8'hF1 && b <= 8'hF3) begin
        cont_left = 2'd3;
        lead_bound = LB_ANY;
        return 1'b1;
      end
      return 1'b0;
    end
    case (lead_bound)
      LB_E0: lo = 8'hA0;
      LB_ED: hi = 8'h9F;
      LB_F0: lo = 8'h90;
      LB_F4: hi = 8'h8F;
      default: ;
    endcase
    if (b < lo || b > hi) return 1'b0;
    cont_left = cont_left - 2'd1;
    lead_bound = LB_ANY;
    return 1'b1;
  endfunction

  // Works out the UTF-8 items caused by one source byte and queues them.
  task automatic transcode_byte(input logic [7:0] b, input logic l, output int n);
    logic [15:0]        cp;
    logic [7:0]         seq [3];
    int                 nb;
    bit                 fail;
    c2u_pkg::out_item_t r;
    nb = 0;
    fail = 1'b0;
    seq = '{8'h00, 8'h00, 8'h00};
    if (!err_flag) begin
      if (cur_mode == c2u_pkg::MODE_UTF8) begin
        if (!utf8_step(b)) fail = 1'b1;
        else if (l && cont_left != 0) fail = 1'b1;
        else begin
          seq[0] = b;
          nb = 1;
        end
      end else begin
        cp = {8'h00, b};
        if (cur_mode == c2u_pkg::MODE_ASCII && b[7]) fail = 1'b1;
        else if (cur_mode == c2u_pkg::MODE_CP1252 && b[7:5] == 3'b100) begin
          cp = WIN_HI[b[4:0]];
          if (cp == 16'h0000) fail = 1'b1;
        end
        if (!fail) begin
          if (cp < 16'h0080) begin
            seq[0] = cp[7:0];
            nb = 1;
          end else if (cp < 16'h0800) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            nb = 2;
          end else begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            nb = 3;
          end
        end
      end
      if (fail) err_flag = 1'b1;
    end
    if (err_flag) begin
      r.out_byte = 8'h00;
      r.run_last = 1'b1;
      r.text_done = l;
      r.error_code = (cur_mode == c2u_pkg::MODE_UTF8) ? c2u_pkg::ERR_UTF8 :
                                                        c2u_pkg::ERR_CHARSET;
      r.total_length = len_count;
      utf8_due.push_back(r);
      n = 1;
    end else begin
      for (int k = 0; k < nb; k++) begin
        if (len_count != 32'hFFFF_FFFF) len_count = len_count + 1;
        r.out_byte = seq[k];
        r.run_last = (k == nb - 1);
        r.text_done = (k == nb - 1) && l;
        r.error_code = c2u_pkg::ERR_NONE;
        r.total_length = len_count;
        utf8_due.push_back(r);
      end
      n = nb;
    end
    if (l) begin
      err_flag = 1'b0;
      cont_left = '0;
      lead_bound = LB_ANY;
      len_count = '0;
    end
  endtask

  task automatic drain();
    @(negedge clk) push <= 1'b0;
    while (utf8_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_charset_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_mode = m;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                           input c2u_pkg::out_item_t res);
    int gap;
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 65) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 30);
    if (gap > 0) begin
      @(negedge clk) push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    in_item <= '{in_byte: b, in_last: l};
    @(posedge clk);
    while (full) @(posedge clk);
    transcode_byte(b, l, n);
    if (typed) begin
      repeat (n) void'(utf8_due.pop_back());
      utf8_due.push_back(res);
    end
    bytes_sent++;
  endtask

  task automatic add_char();
    logic [20:0] cp;
    case ($urandom_range(0, 3))
      0: begin
        cp = 21'($urandom_range(0, 127));
        text_bytes.push_back(cp[7:0]);
      end
      1: begin
        cp = 21'($urandom_range(128, 2047));
        text_bytes.push_back({3'b110, cp[10:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      2: begin
        cp = 21'($urandom_range(2048, 65535));
        if (cp[15:11] == 5'b11011) cp[14] = ~cp[14];
        text_bytes.push_back({4'b1110, cp[15:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        cp = 21'($urandom_range(65536, 1114111));
        text_bytes.push_back({5'b11110, cp[20:18]});
        text_bytes.push_back({2'b10, cp[17:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic build_text();
    int r;
    int n;
    text_bytes.delete();
    if (cur_mode == c2u_pkg::MODE_UTF8) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        n = $urandom_range(1, 5);
        repeat (n) add_char();
        // broken sequence: truncated or one byte overwritten
        if (r == 7) begin
          if ($urandom_range(0, 1) && text_bytes.size() > 1) void'(text_bytes.pop_back());
          else text_bytes[$urandom_range(0, text_bytes.size() - 1)] =
              8'($urandom_range(0, 255));
        end
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) text_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        if (cur_mode == c2u_pkg::MODE_CP1252 && $urandom_range(0, 1))
          text_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
        else if (cur_mode == c2u_pkg::MODE_ASCII && $urandom_range(0, 4) != 0)
          text_bytes.push_back(8'($urandom_range(0, 127)));
        else
          text_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic cmp(input string f, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h got %0h", $time, f, e, a);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    c2u_pkg::out_item_t e;
    if (rst_n && pop && !empty) begin
      pops_seen++;
      if (utf8_due.size() == 0) begin
        $display("%0t: unexpected item expected none got %h", $time, out_item);
        errs++;
      end else begin
        e = utf8_due.pop_front();
        cmp("out_byte", 32'(e.out_byte), 32'(out_item.out_byte));
        cmp("run_last", 32'(e.run_last), 32'(out_item.run_last));
        cmp("text_done", 32'(e.text_done), 32'(out_item.text_done));
        cmp("error_code", 32'(e.error_code), 32'(out_item.error_code));
        cmp("total_length", e.total_length, out_item.total_length);
      end
    end
  end

  initial begin
    int  stall_left;
    bit  rx_quiet;
    bit  hold_done;
    int  r;
    stall_left = 0;
    rx_quiet = 1'b0;
    hold_done = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) rx_quiet = ~rx_quiet;
      // long hold while the sender keeps offering, to fill the block
      if (!hold_done && pops_seen >= 120 && push) begin
        hold_done = 1'b1;
        stall_left = 100;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        r = $urandom_range(0, 99);
        if (rx_quiet || r < 60) stall_left = 0;
        else if (r < 92) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(8, 40);
      end
    end
  end

  initial begin
    int m;
    rows = '{
      '{c2u_pkg::MODE_UTF8, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, c2u_pkg::ERR_NONE, 32'd1}},
      '{c2u_pkg::MODE_UTF8, 8'h7F, 1'b1, 1'b1, '{8'h7F, 1'b1, 1'b1, c2u_pkg::ERR_NONE, 32'd2}},
      '{c2u_pkg::MODE_UTF8, 8'hC2, 1'b0, 1'b0, NO_RES},
      '{c2u_pkg::MODE_UTF8, 8'h80, 1'b1, 1'b0, NO_RES},
      '{c2u_pkg::MODE_UTF8, 8'hE0, 1'b0, 1'b0, NO_RES},
      '{c2u_pkg::MODE_UTF8, 8'h9F, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, c2u_pkg::ERR_UTF8, 32'd1}},
      '{c2u_pkg::MODE_UTF8, 8'hF4, 1'b0, 1'b0, NO_RES},
      '{c2u_pkg::MODE_UTF8, 8'h90, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, c2u_pkg::ERR_UTF8, 32'd1}},
      '{c2u_pkg::MODE_UTF8, 8'h41, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, c2u_pkg::ERR_UTF8, 32'd1}},
      '{c2u_pkg::MODE_UTF8, 8'hED, 1'b0, 1'b0, NO_RES},
      '{c2u_pkg::MODE_UTF8, 8'h9F, 1'b0, 1'b0, NO_RES},
      '{c2u_pkg::MODE_UTF8, 8'hF0, 1'b0, 1'b0, NO_RES},
      '{c2u_pkg::MODE_UTF8, 8'h8F, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, c2u_pkg::ERR_UTF8, 32'd2}},
      '{c2u_pkg::MODE_UTF8, 8'hE1, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, c2u_pkg::ERR_UTF8, 32'd0}},
      '{c2u_pkg::MODE_UTF8, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, c2u_pkg::ERR_UTF8, 32'd0}},
      '{c2u_pkg::MODE_UTF8, 8'hC3, 1'b0, 1'b0, NO_RES},
      '{c2u_pkg::MODE_ASCII, 8'h41, 1'b1, 1'b0, NO_RES},
      '{c2u_pkg::MODE_ASCII, 8'h80, 1'b1, 1'b1,
        '{8'h00, 1'b1, 1'b1, c2u_pkg::ERR_CHARSET, 32'd0}},
      '{c2u_pkg::MODE_ASCII, 8'h7F, 1'b1, 1'b1, '{8'h7F, 1'b1, 1'b1, c2u_pkg::ERR_NONE, 32'd1}},
      '{c2u_pkg::MODE_LATIN1, 8'hFF, 1'b0, 1'b0, NO_RES},
      '{c2u_pkg::MODE_LATIN1, 8'h00, 1'b1, 1'b1,
        '{8'h00, 1'b1, 1'b1, c2u_pkg::ERR_NONE, 32'd3}},
      '{c2u_pkg::MODE_CP1252, 8'h80, 1'b0, 1'b0, NO_RES},
      '{c2u_pkg::MODE_CP1252, 8'h81, 1'b0, 1'b1,
        '{8'h00, 1'b1, 1'b0, c2u_pkg::ERR_CHARSET, 32'd3}},
      '{c2u_pkg::MODE_CP1252, 8'h9F, 1'b1, 1'b1,
        '{8'h00, 1'b1, 1'b1, c2u_pkg::ERR_CHARSET, 32'd3}},
      '{c2u_pkg::MODE_CP1252, 8'h9F, 1'b0, 1'b0, NO_RES},
      '{c2u_pkg::MODE_CP1252, 8'h8D, 1'b1, 1'b1,
        '{8'h00, 1'b1, 1'b1, c2u_pkg::ERR_CHARSET, 32'd2}}
    };
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    set_mode(c2u_pkg::MODE_UTF8);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (rows[i].mode != cur_mode) set_mode(rows[i].mode);
      send_byte(rows[i].b, rows[i].l, rows[i].typed, rows[i].res);
    end

    while (bytes_sent < 370) begin
      if ($urandom_range(0, 3) == 0) set_mode(2'($urandom_range(0, 3)));
      tx_calm = ($urandom_range(0, 3) == 0);
      build_text();
      foreach (text_bytes[i]) begin
        // mode switch in the middle of a text
        if (i > 0 && $urandom_range(0, 59) == 0) begin
          m = $urandom_range(0, 3);
          set_mode(2'(m));
        end
        send_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, NO_RES);
      end
    end

    @(negedge clk) push <= 1'b0;
    while (utf8_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errs == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/c2u_pkg.sv
hdl/c2u_front.sv
hdl/c2u_queue.sv
hdl/c2u_back.sv
hdl/charset_to_utf8_converter.sv
hdl/c2u_checker.sv
tb/tb_top.sv
